// ===== sv/position_pid_controller_top_defines.svh =====
// Assertion helpers for the files that check their own logic.
`ifndef POSITION_PID_CONTROLLER_TOP_DEFINES_SVH
`define POSITION_PID_CONTROLLER_TOP_DEFINES_SVH

// A property checked at every rising edge outside reset.
`define PPID_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must be followed by an outcome in the next cycle.
`define PPID_ASSERT_NEXT(label, cond, outcome, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (cond) |=> (outcome)) else $error(msg);

`endif

// ===== sv/ppid_pkg.sv =====
package ppid_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int GAIN_W      = 24;
    localparam int PERIOD_W    = 16;
    localparam int BAND_W      = 8;
    localparam int DECAY_W     = 16;
    localparam int CUR_W       = 24;
    localparam int INTEG_W     = 25;
    localparam int DTERM_W     = 32;
    localparam int KDB_W       = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN       = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEG_GAIN      = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN      = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_LIMIT  = 8'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_PERIOD   = 8'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DERIV_BANDWIDTH = 8'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_DERIV_DECAY     = 8'd6;

    localparam logic [GAIN_W-1:0]   LIMIT_RST  = 24'd655360;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 16'd328;
    localparam logic [BAND_W-1:0]   BAND_RST   = 8'd50;
    localparam logic [DECAY_W-1:0]  DECAY_RST  = 16'd49152;

    localparam logic signed [CUR_W-1:0] CUR_MAX = 24'sh7FFFFF;
    localparam logic signed [CUR_W-1:0] CUR_MIN = 24'sh800000;

    typedef struct packed {
        logic [GAIN_W-1:0]   prop_gain;
        logic [GAIN_W-1:0]   integ_gain;
        logic [GAIN_W-1:0]   deriv_gain;
        logic [GAIN_W-1:0]   integral_limit;
        logic [PERIOD_W-1:0] sample_period;
        logic [BAND_W-1:0]   deriv_bandwidth;
        logic [DECAY_W-1:0]  deriv_decay;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        S_KDB,
        S_INTEG,
        S_PROP,
        S_IGAIN,
        S_DERIV,
        S_DECAY,
        S_DRAIN
    } step_t;

endpackage

// ===== sv/position_pid_controller_top.sv =====
// Channel  | Direction | Handshake            | Beat contents
// ---------+-----------+----------------------+--------------------------------------------
// in       | input     | in_valid / in_stall  | measured_position, target_position, clear
// out      | output    | out_valid / out_stall| reference_current, saturated
// cfg      | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// After acceptance, a normal sample runs seven steps through the one shared registered
// multiplier, then sums and saturates in the finish state, and returns to the idle state
// in which the next beat is taken. A sample with clear set goes straight to finish.
// Asynchronous reset clears configuration, loop state and the output valid flag.
// While the output register is full and stalled, the final sum waits and no new input
// beat is taken.
`include "position_pid_controller_top_defines.svh"

module position_pid_controller_top #(
    parameter int POSITION_WIDTH = 20
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [POSITION_WIDTH-1:0]   measured_position,
    input  logic signed [POSITION_WIDTH-1:0]   target_position,
    input  logic                               clear,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [ppid_pkg::CUR_W-1:0]  reference_current,
    output logic                               saturated,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [ppid_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ppid_pkg::GAIN_W-1:0]        cfg_data
);
    import ppid_pkg::*;

    localparam int ERR_W   = POSITION_WIDTH + 1;
    localparam int DIFF_W  = POSITION_WIDTH + 2;
    localparam int AW      = (DIFF_W > DTERM_W) ? DIFF_W : DTERM_W;
    localparam int PROD_W  = AW + KDB_W + 1;
    localparam int P_W     = POSITION_WIDTH + 10;
    localparam int I_W     = 22;
    localparam int D1_W    = 48;
    localparam int DSUM_W  = D1_W + 1;
    localparam int SUM_W   = ((P_W > DTERM_W) ? P_W : DTERM_W) + 2;

    localparam logic signed [PROD_W-1:0] HALF4  = PROD_W'(1) << 3;
    localparam logic signed [PROD_W-1:0] HALF16 = PROD_W'(1) << 15;
    localparam logic signed [PROD_W-1:0] HALF28 = PROD_W'(1) << 27;
    localparam logic signed [PROD_W-1:0] CAP    = PROD_W'(1) << 62;
    localparam logic signed [DSUM_W-1:0] DT_MAX = (DSUM_W'(1) << (DTERM_W - 1)) - DSUM_W'(1);
    localparam logic signed [DSUM_W-1:0] DT_MIN = -(DSUM_W'(1) << (DTERM_W - 1));
    localparam logic signed [SUM_W-1:0]  SUM_HI = SUM_W'(CUR_MAX);
    localparam logic signed [SUM_W-1:0]  SUM_LO = SUM_W'(CUR_MIN);

    cfg_t cfg;

    state_t state_reg, state_next;
    step_t  step_reg, step_next;
    logic   out_valid_reg, out_valid_next;

    logic signed [INTEG_W-1:0] integ_reg, integ_next;
    logic signed [ERR_W-1:0]   last_err_reg, last_err_next;
    logic signed [DTERM_W-1:0] deriv_reg, deriv_next;

    logic signed [ERR_W-1:0]  e_reg, e_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic [KDB_W-1:0]         kdb_reg, kdb_next;
    logic signed [P_W-1:0]    p_reg, p_next;
    logic signed [I_W-1:0]    i_reg, i_next;
    logic signed [D1_W-1:0]   d1_reg, d1_next;
    logic signed [CUR_W-1:0]  cur_reg, cur_next;
    logic                     sat_reg, sat_next;

    logic signed [AW-1:0]     mul_a;
    logic [KDB_W-1:0]         mul_b;
    logic signed [PROD_W-1:0] prod;

    logic signed [PROD_W-1:0] rnd4, rnd16, rnd28, integ_sum, lim_pos, lim_neg, capped, rnd_cap;
    logic signed [INTEG_W-1:0] integ_clamped;
    logic signed [DSUM_W-1:0]  d_sum;
    logic signed [DTERM_W-1:0] d_clamped;
    logic signed [SUM_W-1:0]   cur_sum;
    logic signed [CUR_W-1:0]   cur_clamped;
    logic                      cur_clip;

    ppid_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_ready (cfg_ready),
        .cfg       (cfg)
    );

    ppid_mul #(
        .AW (AW),
        .BW (KDB_W)
    ) u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (step_reg)
            S_KDB:
            begin
                mul_a = AW'(cfg.deriv_gain);
                mul_b = KDB_W'(cfg.deriv_bandwidth);
            end
            S_INTEG:
            begin
                mul_a = AW'(e_reg);
                mul_b = KDB_W'(cfg.sample_period);
            end
            S_PROP:
            begin
                mul_a = AW'(e_reg);
                mul_b = KDB_W'(cfg.prop_gain);
            end
            S_IGAIN:
            begin
                mul_a = AW'(integ_reg);
                mul_b = KDB_W'(cfg.integ_gain);
            end
            S_DERIV:
            begin
                mul_a = AW'(diff_reg);
                mul_b = kdb_reg;
            end
            S_DECAY:
            begin
                mul_a = AW'(deriv_reg);
                mul_b = KDB_W'(cfg.deriv_decay);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign rnd4      = (prod + HALF4) >>> 4;
    assign rnd16     = (prod + HALF16) >>> 16;
    assign rnd28     = (prod + HALF28) >>> 28;
    assign integ_sum = PROD_W'(integ_reg) + rnd4;
    assign lim_pos   = $signed(PROD_W'(cfg.integral_limit));
    assign lim_neg   = -lim_pos;
    assign capped    = (prod > CAP) ? CAP : ((prod < -CAP) ? -CAP : prod);
    assign rnd_cap   = (capped + HALF16) >>> 16;
    assign d_sum     = DSUM_W'(d1_reg) + $signed(rnd16[DSUM_W-1:0]);
    assign cur_sum   = SUM_W'(p_reg) + SUM_W'(i_reg) + SUM_W'(deriv_reg);

    always_comb
    begin
        if (integ_sum > lim_pos)
        begin
            integ_clamped = lim_pos[INTEG_W-1:0];
        end
        else if (integ_sum < lim_neg)
        begin
            integ_clamped = lim_neg[INTEG_W-1:0];
        end
        else
        begin
            integ_clamped = integ_sum[INTEG_W-1:0];
        end

        if (d_sum > DT_MAX)
        begin
            d_clamped = DT_MAX[DTERM_W-1:0];
        end
        else if (d_sum < DT_MIN)
        begin
            d_clamped = DT_MIN[DTERM_W-1:0];
        end
        else
        begin
            d_clamped = d_sum[DTERM_W-1:0];
        end

        if (cur_sum > SUM_HI)
        begin
            cur_clamped = CUR_MAX;
            cur_clip    = 1'b1;
        end
        else if (cur_sum < SUM_LO)
        begin
            cur_clamped = CUR_MIN;
            cur_clip    = 1'b1;
        end
        else
        begin
            cur_clamped = cur_sum[CUR_W-1:0];
            cur_clip    = 1'b0;
        end
    end

    // Each run step but the first consumes the product issued in the step before; each but the last issues one.
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        integ_next     = integ_reg;
        last_err_next  = last_err_reg;
        deriv_next     = deriv_reg;
        e_next         = e_reg;
        diff_next      = diff_reg;
        kdb_next       = kdb_reg;
        p_next         = p_reg;
        i_next         = i_reg;
        d1_next        = d1_reg;
        cur_next       = cur_reg;
        sat_next       = sat_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (clear)
                    begin
                        integ_next    = '0;
                        last_err_next = '0;
                        deriv_next    = '0;
                        p_next        = '0;
                        i_next        = '0;
                        state_next    = ST_FINISH;
                    end
                    else
                    begin
                        e_next     = ERR_W'(target_position) - ERR_W'(measured_position);
                        step_next  = S_KDB;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                step_next = step_t'(step_reg + 3'd1);
                unique case (step_reg)
                    S_KDB:   diff_next  = DIFF_W'(e_reg) - DIFF_W'(last_err_reg);
                    S_INTEG: kdb_next   = prod[KDB_W-1:0];
                    S_PROP:  integ_next = integ_clamped;
                    S_IGAIN: p_next     = rnd16[P_W-1:0];
                    S_DERIV: i_next     = rnd28[I_W-1:0];
                    S_DECAY: d1_next    = rnd_cap[D1_W-1:0];
                    S_DRAIN:
                    begin
                        deriv_next    = d_clamped;
                        last_err_next = e_reg;
                        step_next     = S_KDB;
                        state_next    = ST_FINISH;
                    end
                    default: step_next = S_KDB;
                endcase
            end
            ST_FINISH:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    out_valid_next = 1'b1;
                    cur_next       = cur_clamped;
                    sat_next       = cur_clip;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= S_KDB;
            out_valid_reg <= 1'b0;
            integ_reg     <= '0;
            last_err_reg  <= '0;
            deriv_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            integ_reg     <= integ_next;
            last_err_reg  <= last_err_next;
            deriv_reg     <= deriv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        e_reg    <= e_next;
        diff_reg <= diff_next;
        kdb_reg  <= kdb_next;
        p_reg    <= p_next;
        i_reg    <= i_next;
        d1_reg   <= d1_next;
        cur_reg  <= cur_next;
        sat_reg  <= sat_next;
    end

    assign in_stall          = (state_reg != ST_IDLE);
    assign out_valid         = out_valid_reg;
    assign reference_current = cur_reg;
    assign saturated         = sat_reg;

    `PPID_ASSERT_NEXT(a_run_start, in_valid && !in_stall && !clear,
        state_reg == ST_RUN && step_reg == S_KDB, "sample did not start the step sequence")
    `PPID_ASSERT_NEXT(a_clear_state, in_valid && !in_stall && clear,
        state_reg == ST_FINISH && integ_reg == '0 && last_err_reg == '0 && deriv_reg == '0,
        "clear did not zero the loop state")
    `PPID_ASSERT_NEXT(a_finish_out, state_reg == ST_FINISH && !(out_valid && out_stall),
        out_valid && state_reg == ST_IDLE, "finished sum was not delivered")
    `PPID_ASSERT(a_finish_wait,
        state_reg == ST_FINISH && out_valid && out_stall |=> state_reg == ST_FINISH,
        "final sum overwrote a stalled result")

endmodule

// ===== sv/ppid_cfg.sv =====
module ppid_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [ppid_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ppid_pkg::GAIN_W-1:0]      cfg_data,
    output logic                             cfg_ready,
    output ppid_pkg::cfg_t                   cfg
);
    import ppid_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PROP_GAIN:       cfg_next.prop_gain       = cfg_data;
                REG_INTEG_GAIN:      cfg_next.integ_gain      = cfg_data;
                REG_DERIV_GAIN:      cfg_next.deriv_gain      = cfg_data;
                REG_INTEGRAL_LIMIT:  cfg_next.integral_limit  = cfg_data;
                REG_SAMPLE_PERIOD:   cfg_next.sample_period   = cfg_data[PERIOD_W-1:0];
                REG_DERIV_BANDWIDTH: cfg_next.deriv_bandwidth = cfg_data[BAND_W-1:0];
                REG_DERIV_DECAY:     cfg_next.deriv_decay     = cfg_data[DECAY_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain       <= '0;
            cfg_reg.integ_gain      <= '0;
            cfg_reg.deriv_gain      <= '0;
            cfg_reg.integral_limit  <= LIMIT_RST;
            cfg_reg.sample_period   <= PERIOD_RST;
            cfg_reg.deriv_bandwidth <= BAND_RST;
            cfg_reg.deriv_decay     <= DECAY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

endmodule

// ===== sv/ppid_mul.sv =====
module ppid_mul #(
    parameter int AW = 34,
    parameter int BW = 32
) (
    input  logic                 clk,
    input  logic signed [AW-1:0] a,
    input  logic [BW-1:0]        b,
    output logic signed [AW+BW:0] prod
);
    logic signed [AW+BW:0] prod_reg;
    logic signed [AW+BW:0] prod_next;

    assign prod_next = a * $signed({1'b0, b});

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule
